/* hdl/tmc_pkg.sv */
// ----------------------------------------------------------------------------
// Thermostat mode controller package
// Request and result payload types, mode codes, register indexes and reset constants.
// ----------------------------------------------------------------------------
package tmc_pkg;

    localparam int TEMP_W = 10;
    localparam int HOLD_W = 4;
    localparam int MODE_W = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [MODE_W-1:0] MODE_AUTO = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ON   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OFF  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SET  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT_MIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT_MAX = 2'd2;

    localparam logic [HOLD_W-1:0] HOLD_TICKS_RST   = 4'd5;
    localparam logic [TEMP_W-1:0] SETPOINT_MIN_RST = 10'd100;
    localparam logic [TEMP_W-1:0] SETPOINT_MAX_RST = 10'd300;
    localparam logic [TEMP_W-1:0] SETPOINT_RST     = 10'd150;

    typedef struct packed {
        logic              key_plus;
        logic              key_minus;
        logic              key_show_temp;
        logic              key_next_mode;
        logic [TEMP_W-1:0] room_temp;
    } t_in_item;

    typedef struct packed {
        logic              heater_on;
        logic [MODE_W-1:0] mode;
        logic [TEMP_W-1:0] setpoint;
        logic              show_room_temp;
        logic [TEMP_W-1:0] shown_temp;
    } t_out_item;

endpackage

/* hdl/tmc_stream_if.sv */
// ----------------------------------------------------------------------------
// Thermostat mode controller stream interface
// Valid/ready channel carrying one payload of a chosen type.
// ----------------------------------------------------------------------------
interface tmc_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hdl/thermostat_mode_controller.sv */
// ----------------------------------------------------------------------------
// Thermostat mode controller
// Four-mode heater control with manual override hold and setpoint editing.
// ----------------------------------------------------------------------------
//  Channel    Dir  Payload        Handshake
//  i_in_ch    in   t_in_item      valid/ready, request taken on valid & ready
//  o_out_ch   out  t_out_item     valid/ready, result taken on valid & ready
//  i_cfg_*    in   index, data    write on i_cfg_we, no wait
//
// One request per cycle while the skid register is empty: the mode update is a
// single pass of compares and a small counter, and the result is registered.
// A two-entry result buffer (output register plus skid register) keeps the
// input open for one more request while the sink stalls.
// Reset is synchronous and active low; it restores modes, setpoint and config.
// ----------------------------------------------------------------------------
module thermostat_mode_controller
    import tmc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tmc_stream_if.sink            i_in_ch,
    tmc_stream_if.source          o_out_ch,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [HOLD_W-1:0] r_hold_ticks;
    logic [TEMP_W-1:0] r_setpoint_min;
    logic [TEMP_W-1:0] r_setpoint_max;

    logic [MODE_W-1:0] r_mode,     n_mode;
    logic              r_heater,   n_heater;
    logic [HOLD_W-1:0] r_hold,     n_hold;
    logic [TEMP_W-1:0] r_setpoint, n_setpoint;

    t_out_item r_out_data;
    logic      r_out_valid;
    t_out_item r_skid_data;
    logic      r_skid_valid;

    t_in_item  in_item;
    t_out_item result;
    logic      in_fire;
    logic      out_fire;
    logic [TEMP_W-1:0] sp_up;

    assign in_item         = i_in_ch.data;
    assign i_in_ch.ready   = !r_skid_valid;
    assign in_fire         = i_in_ch.valid && !r_skid_valid;
    assign o_out_ch.valid  = r_out_valid;
    assign o_out_ch.data   = r_out_data;
    assign out_fire        = r_out_valid && o_out_ch.ready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_ticks   <= HOLD_TICKS_RST;
            r_setpoint_min <= SETPOINT_MIN_RST;
            r_setpoint_max <= SETPOINT_MAX_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_HOLD_TICKS) begin
                r_hold_ticks <= i_cfg_data[HOLD_W-1:0];
            end
            if (i_cfg_idx == REG_SETPOINT_MIN) begin
                r_setpoint_min <= i_cfg_data[TEMP_W-1:0];
            end
            if (i_cfg_idx == REG_SETPOINT_MAX) begin
                r_setpoint_max <= i_cfg_data[TEMP_W-1:0];
            end
        end
    end

    // Mode update for one tick
    always_comb begin
        n_mode     = r_mode;
        n_heater   = r_heater;
        n_hold     = r_hold;
        n_setpoint = r_setpoint;
        sp_up      = r_setpoint;
        unique case (r_mode)
            MODE_AUTO: begin
                if (r_hold == '0) begin
                    n_heater = (in_item.room_temp < r_setpoint);
                end
                if (in_item.key_minus) begin
                    n_heater = 1'b0;
                    n_hold   = r_hold_ticks;
                end else if (in_item.key_plus) begin
                    n_heater = 1'b1;
                    n_hold   = r_hold_ticks;
                end else if (r_hold != '0) begin
                    n_hold = r_hold - 1'b1;
                end
                if (in_item.key_next_mode) begin
                    n_mode = MODE_ON;
                    n_hold = '0;
                end
            end
            MODE_ON: begin
                if (r_hold == '0) begin
                    n_heater = 1'b1;
                end
                if (in_item.key_minus && n_heater) begin
                    n_heater = 1'b0;
                    n_hold   = r_hold_ticks;
                end else if (r_hold != '0) begin
                    n_hold = r_hold - 1'b1;
                end
                if (in_item.key_next_mode) begin
                    n_mode = MODE_OFF;
                    n_hold = '0;
                end
            end
            MODE_OFF: begin
                if (r_hold == '0) begin
                    n_heater = 1'b0;
                end
                if (in_item.key_plus && !n_heater) begin
                    n_heater = 1'b1;
                    n_hold   = r_hold_ticks;
                end else if (r_hold != '0) begin
                    n_hold = r_hold - 1'b1;
                end
                if (in_item.key_next_mode) begin
                    n_mode = MODE_SET;
                    n_hold = '0;
                end
            end
            MODE_SET: begin
                n_heater = 1'b0;
                // The minus test sees the setpoint after the plus step.
                if (in_item.key_plus && (r_setpoint < r_setpoint_max)) begin
                    sp_up = r_setpoint + 1'b1;
                end
                n_setpoint = sp_up;
                if (in_item.key_minus && (sp_up > r_setpoint_min)) begin
                    n_setpoint = sp_up - 1'b1;
                end
                if (in_item.key_next_mode) begin
                    n_mode = MODE_AUTO;
                end
            end
        endcase

        result.heater_on      = n_heater;
        result.mode           = n_mode;
        result.setpoint       = n_setpoint;
        result.show_room_temp = in_item.key_show_temp;
        result.shown_temp     = in_item.key_show_temp ? in_item.room_temp : '0;
    end

    // Controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_AUTO;
            r_heater   <= 1'b0;
            r_hold     <= '0;
            r_setpoint <= SETPOINT_RST;
        end else if (in_fire) begin
            r_mode     <= n_mode;
            r_heater   <= n_heater;
            r_hold     <= n_hold;
            r_setpoint <= n_setpoint;
        end
    end

    // Result buffer: output register fed from the skid register first.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_fire) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_fire;
            end
        end else if (in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_fire) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
            end else if (in_fire) begin
                r_out_data <= result;
            end
        end else if (in_fire) begin
            r_skid_data <= result;
        end
    end

`ifndef ASSERT_OFF
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a result while output register is empty");

    a_stall_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && r_out_valid && !o_out_ch.ready) |=> r_skid_valid)
        else $error("request taken during stall was not captured in skid register");

    a_edit_heater_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && r_mode == MODE_SET) |=> !r_heater)
        else $error("heater on after a tick in setpoint edit mode");

    a_edit_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_SET) |-> (r_hold == '0))
        else $error("override hold active in setpoint edit mode");
`endif

endmodule
